[hw/rtl/alusf_pkg.sv]
// shared types, operation codes and byte adder function of the status flag alu
`timescale 1ns / 1ps
package alusf_pkg;

	localparam int unsigned ModeW = 5;
	localparam int unsigned DataW = 16;
	localparam int unsigned ByteW = 8;

	localparam logic [ModeW-1:0] MODE_ADC = 5'd0;
	localparam logic [ModeW-1:0] MODE_AND = 5'd1;
	localparam logic [ModeW-1:0] MODE_ASL = 5'd2;
	localparam logic [ModeW-1:0] MODE_CMP = 5'd3;
	localparam logic [ModeW-1:0] MODE_DEC = 5'd4;
	localparam logic [ModeW-1:0] MODE_EOR = 5'd5;
	localparam logic [ModeW-1:0] MODE_INC = 5'd6;
	localparam logic [ModeW-1:0] MODE_LD  = 5'd7;
	localparam logic [ModeW-1:0] MODE_LSR = 5'd8;
	localparam logic [ModeW-1:0] MODE_OR  = 5'd9;
	localparam logic [ModeW-1:0] MODE_ROL = 5'd10;
	localparam logic [ModeW-1:0] MODE_ROR = 5'd11;
	localparam logic [ModeW-1:0] MODE_SBC = 5'd12;
	localparam logic [ModeW-1:0] MODE_ST  = 5'd13;
	localparam logic [ModeW-1:0] MODE_ADW = 5'd14;
	localparam logic [ModeW-1:0] MODE_CPW = 5'd15;
	localparam logic [ModeW-1:0] MODE_LDW = 5'd16;
	localparam logic [ModeW-1:0] MODE_SBW = 5'd17;

	typedef struct packed {
		logic c;
		logic n;
		logic v;
		logic h;
		logic z;
	} flags_t;

	typedef struct packed {
		logic [ByteW-1:0] r;
		flags_t           f;
	} add_res_t;

	function automatic add_res_t byte_add(input logic [ByteW-1:0] a,
		input logic [ByteW-1:0] b, input logic cin);
		logic [ByteW:0] sum;
		add_res_t       res;
		sum     = {1'b0, a} + {1'b0, b} + {{ByteW{1'b0}}, cin};
		res.r   = sum[ByteW-1:0];
		res.f.c = sum[ByteW];
		res.f.n = sum[ByteW-1];
		res.f.v = ~(a[ByteW-1] ^ b[ByteW-1]) & (a[ByteW-1] ^ sum[ByteW-1]);
		res.f.h = a[4] ^ b[4] ^ sum[4];
		res.f.z = (sum[ByteW-1:0] == '0);
		return res;
	endfunction

endpackage

[hw/rtl/alusf_exec.sv]
// combinational datapath and flag logic of the status flag alu
`timescale 1ns / 1ps
module alusf_exec (
	input  logic [4:0]       mode,
	input  logic [15:0]      operand_x,
	input  logic [15:0]      operand_y,
	input  alusf_pkg::flags_t flags_in,
	output logic [15:0]      result,
	output alusf_pkg::flags_t flags_out
);
	import alusf_pkg::*;

	logic [7:0]  xb, yb, xh, yh;
	logic [7:0]  r8;
	logic [7:0]  d8;
	logic [15:0] d16;
	add_res_t    add_b, sub_b, lo_a, hi_a, lo_s, hi_s;

	assign xb = operand_x[7:0];
	assign yb = operand_y[7:0];
	assign xh = operand_x[15:8];
	assign yh = operand_y[15:8];

	assign d8  = xb - yb;
	assign d16 = operand_x - operand_y;

	always_comb begin
		add_b = byte_add(xb, yb, flags_in.c);
		sub_b = byte_add(xb, ~yb, flags_in.c);
		lo_a  = byte_add(xb, yb, 1'b0);
		hi_a  = byte_add(xh, yh, lo_a.f.c);
		lo_s  = byte_add(xb, ~yb, 1'b1);
		hi_s  = byte_add(xh, ~yh, lo_s.f.c);
	end

	always_comb begin
		flags_out = flags_in;
		result    = '0;
		r8        = '0;
		case (mode)
			MODE_ADC: begin
				result    = {8'h00, add_b.r};
				flags_out = add_b.f;
			end
			MODE_SBC: begin
				result    = {8'h00, sub_b.r};
				flags_out = sub_b.f;
			end
			MODE_AND, MODE_ASL, MODE_DEC, MODE_EOR, MODE_INC, MODE_LD, MODE_LSR,
			MODE_OR, MODE_ROL, MODE_ROR: begin
				case (mode)
					MODE_AND: r8 = xb & yb;
					MODE_ASL: begin
						r8          = {xb[6:0], 1'b0};
						flags_out.c = xb[7];
					end
					MODE_DEC: r8 = xb - 8'h01;
					MODE_EOR: r8 = xb ^ yb;
					MODE_INC: r8 = xb + 8'h01;
					MODE_LD:  r8 = yb;
					MODE_LSR: begin
						r8          = {1'b0, xb[7:1]};
						flags_out.c = xb[0];
					end
					MODE_OR:  r8 = xb | yb;
					MODE_ROL: begin
						r8          = {xb[6:0], flags_in.c};
						flags_out.c = xb[7];
					end
					MODE_ROR: begin
						r8          = {flags_in.c, xb[7:1]};
						flags_out.c = xb[0];
					end
					default:  r8 = '0;
				endcase
				result      = {8'h00, r8};
				flags_out.n = r8[7];
				flags_out.z = (r8 == '0);
			end
			MODE_CMP: begin
				result      = {8'h00, xb};
				flags_out.n = d8[7];
				flags_out.z = (xb == yb);
				flags_out.c = (xb >= yb);
			end
			MODE_ST: begin
				result = {8'h00, yb};
			end
			MODE_ADW: begin
				result      = {hi_a.r, lo_a.r};
				flags_out   = hi_a.f;
				flags_out.z = ({hi_a.r, lo_a.r} == '0);
			end
			MODE_SBW: begin
				result      = {hi_s.r, lo_s.r};
				flags_out   = hi_s.f;
				flags_out.z = ({hi_s.r, lo_s.r} == '0);
			end
			MODE_CPW: begin
				result      = operand_x;
				flags_out.n = d16[15];
				flags_out.z = (operand_x == operand_y);
				flags_out.c = (operand_x >= operand_y);
			end
			MODE_LDW: begin
				result      = operand_y;
				flags_out.n = operand_y[15];
				flags_out.z = (operand_y == '0);
			end
			default: begin
				result    = '0;
				flags_out = flags_in;
			end
		endcase
	end

endmodule

[hw/rtl/alu_8_16_bit_with_status_flags_core.sv]
// top level of the 8/16-bit alu with status flags: input register, datapath, result register
// a word accepted by start passes the input register and the result register before it is shown with done
// throughput: one word per cycle, set by the single registered pass through the datapath
// busy stays low, so start is taken at every edge; the receiver cannot stall
// reset clears the stage valid bits and the done strobe; payload registers are not reset
`timescale 1ns / 1ps
module alu_8_16_bit_with_status_flags_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [4:0]  mode,
	input  logic [15:0] operand_x,
	input  logic [15:0] operand_y,
	input  logic        carry_in,
	input  logic        negative_in,
	input  logic        overflow_in,
	input  logic        half_carry_in,
	input  logic        zero_in,
	output logic        done,
	output logic [15:0] result,
	output logic        carry_out,
	output logic        negative_out,
	output logic        overflow_out,
	output logic        half_carry_out,
	output logic        zero_out
);
	import alusf_pkg::*;

	logic        valid_s1;
	logic [4:0]  mode_s1;
	logic [15:0] x_s1, y_s1;
	flags_t      flags_s1;
	logic [15:0] res_comb;
	flags_t      flags_comb;
	logic        valid_s2;
	logic [15:0] res_s2;
	flags_t      flags_s2;

	assign busy = 1'b0;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start & ~busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			mode_s1    <= mode;
			x_s1       <= operand_x;
			y_s1       <= operand_y;
			flags_s1.c <= carry_in;
			flags_s1.n <= negative_in;
			flags_s1.v <= overflow_in;
			flags_s1.h <= half_carry_in;
			flags_s1.z <= zero_in;
		end
	end

	alusf_exec u_exec (
		.mode      (mode_s1),
		.operand_x (x_s1),
		.operand_y (y_s1),
		.flags_in  (flags_s1),
		.result    (res_comb),
		.flags_out (flags_comb)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			res_s2   <= res_comb;
			flags_s2 <= flags_comb;
		end
	end

	assign done           = valid_s2;
	assign result         = res_s2;
	assign carry_out      = flags_s2.c;
	assign negative_out   = flags_s2.n;
	assign overflow_out   = flags_s2.v;
	assign half_carry_out = flags_s2.h;
	assign zero_out       = flags_s2.z;

	a_start_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##2 done)
		else $error("accepted word did not produce done two cycles later");

	a_no_spurious_done: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |=> !done)
		else $error("done raised without a word in the input stage");

	a_byte_upper_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && (mode_s1 == MODE_ADC || mode_s1 == MODE_SBC || mode_s1 == MODE_AND ||
		mode_s1 == MODE_CMP || mode_s1 == MODE_LD || mode_s1 == MODE_ST) |=>
		result[15:8] == 8'h00)
		else $error("byte operation left upper result byte nonzero");

endmodule

[bench/alu_8_16_bit_with_status_flags_core_test.sv]
// self-checking testbench of the 8/16-bit alu with status flags: directed and random words
`timescale 1ns / 1ps
module alu_8_16_bit_with_status_flags_core_test;
	import alusf_pkg::*;

	localparam int CycleLimit = 200000;
	localparam int ShownMismatches = 10;
	localparam int RandomWords = 1400;
	localparam int Phases = 4;

	typedef struct packed {
		logic [ModeW-1:0] mode;
		logic [DataW-1:0] x;
		logic [DataW-1:0] y;
		logic             c;
		logic             n;
		logic             v;
		logic             h;
		logic             z;
	} op_word_t;

	typedef struct packed {
		logic [DataW-1:0] value;
		logic             c;
		logic             n;
		logic             v;
		logic             h;
		logic             z;
	} flag_result_t;

	class alu_result_board;
		flag_result_t expected_words[$];
		int           mismatches;

		function flag_result_t add_bytes(logic [7:0] a, logic [7:0] b, logic cin,
			flag_result_t f);
			logic [8:0] s;
			s = {1'b0, a} + {1'b0, b} + {8'h00, cin};
			f.value = {8'h00, s[7:0]};
			f.n = s[7];
			f.v = ~(a[7] ^ b[7]) & (a[7] ^ s[7]);
			f.h = a[4] ^ b[4] ^ s[4];
			f.z = (s[7:0] == 8'h00);
			f.c = s[8];
			return f;
		endfunction

		function flag_result_t nz_byte(flag_result_t f);
			f.n = f.value[7];
			f.z = (f.value[7:0] == 8'h00);
			return f;
		endfunction

		function flag_result_t compute_result(op_word_t w);
			flag_result_t f;
			logic [7:0]   xb;
			logic [7:0]   yb;
			logic [7:0]   low;
			logic [7:0]   diff_b;
			logic [15:0]  diff_w;
			xb = w.x[7:0];
			yb = w.y[7:0];
			f = '{value: '0, c: w.c, n: w.n, v: w.v, h: w.h, z: w.z};
			case (w.mode)
				MODE_ADC: f = add_bytes(xb, yb, w.c, f);
				MODE_AND: begin
					f.value = {8'h00, xb & yb};
					f = nz_byte(f);
				end
				MODE_ASL: begin
					f.c = xb[7];
					f.value = {8'h00, xb[6:0], 1'b0};
					f = nz_byte(f);
				end
				MODE_CMP: begin
					diff_b = xb - yb;
					f.n = diff_b[7];
					f.z = (xb == yb);
					f.c = (xb >= yb);
					f.value = {8'h00, xb};
				end
				MODE_DEC: begin
					f.value = {8'h00, xb - 8'd1};
					f = nz_byte(f);
				end
				MODE_EOR: begin
					f.value = {8'h00, xb ^ yb};
					f = nz_byte(f);
				end
				MODE_INC: begin
					f.value = {8'h00, xb + 8'd1};
					f = nz_byte(f);
				end
				MODE_LD: begin
					f.value = {8'h00, yb};
					f = nz_byte(f);
				end
				MODE_LSR: begin
					f.c = xb[0];
					f.value = {9'h000, xb[7:1]};
					f = nz_byte(f);
				end
				MODE_OR: begin
					f.value = {8'h00, xb | yb};
					f = nz_byte(f);
				end
				MODE_ROL: begin
					f.value = {8'h00, xb[6:0], w.c};
					f.c = xb[7];
					f = nz_byte(f);
				end
				MODE_ROR: begin
					f.value = {8'h00, w.c, xb[7:1]};
					f.c = xb[0];
					f = nz_byte(f);
				end
				MODE_SBC: f = add_bytes(xb, ~yb, w.c, f);
				MODE_ST: f.value = {8'h00, yb};
				MODE_ADW: begin
					f = add_bytes(xb, yb, 1'b0, f);
					low = f.value[7:0];
					f = add_bytes(w.x[15:8], w.y[15:8], f.c, f);
					f.value = {f.value[7:0], low};
					f.z = (f.value == 16'h0000);
				end
				MODE_CPW: begin
					diff_w = w.x - w.y;
					f.n = diff_w[15];
					f.z = (w.x == w.y);
					f.c = (w.x >= w.y);
					f.value = w.x;
				end
				MODE_LDW: begin
					f.value = w.y;
					f.n = w.y[15];
					f.z = (w.y == 16'h0000);
				end
				MODE_SBW: begin
					f = add_bytes(xb, ~yb, 1'b1, f);
					low = f.value[7:0];
					f = add_bytes(w.x[15:8], ~w.y[15:8], f.c, f);
					f.value = {f.value[7:0], low};
					f.z = (f.value == 16'h0000);
				end
				default: f.value = '0;
			endcase
			return f;
		endfunction

		function void note_op(op_word_t w);
			expected_words.push_back(compute_result(w));
		endfunction

		function void check_word(flag_result_t got);
			flag_result_t exp;
			if (expected_words.size() == 0) begin
				mismatches++;
				if (mismatches <= ShownMismatches)
					$display("unexpected result word %h c%b n%b v%b h%b z%b",
						got.value, got.c, got.n, got.v, got.h, got.z);
				return;
			end
			exp = expected_words.pop_front();
			if (got.value !== exp.value || got.c !== exp.c || got.n !== exp.n ||
				got.v !== exp.v || got.h !== exp.h || got.z !== exp.z) begin
				mismatches++;
				if (mismatches <= ShownMismatches)
					$display("mismatch: expected %h c%b n%b v%b h%b z%b, got %h c%b n%b v%b h%b z%b",
						exp.value, exp.c, exp.n, exp.v, exp.h, exp.z,
						got.value, got.c, got.n, got.v, got.h, got.z);
			end
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	logic [ModeW-1:0] mode;
	logic [DataW-1:0] operand_x;
	logic [DataW-1:0] operand_y;
	logic             carry_in;
	logic             negative_in;
	logic             overflow_in;
	logic             half_carry_in;
	logic             zero_in;
	logic             done;
	logic [DataW-1:0] result;
	logic             carry_out;
	logic             negative_out;
	logic             overflow_out;
	logic             half_carry_out;
	logic             zero_out;

	alu_result_board board;
	int              cycle_count;

	alu_8_16_bit_with_status_flags_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.mode(mode),
		.operand_x(operand_x),
		.operand_y(operand_y),
		.carry_in(carry_in),
		.negative_in(negative_in),
		.overflow_in(overflow_in),
		.half_carry_in(half_carry_in),
		.zero_in(zero_in),
		.done(done),
		.result(result),
		.carry_out(carry_out),
		.negative_out(negative_out),
		.overflow_out(overflow_out),
		.half_carry_out(half_carry_out),
		.zero_out(zero_out)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CycleLimit) begin
			$display("simulation failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				board.check_word('{value: result, c: carry_out, n: negative_out,
					v: overflow_out, h: half_carry_out, z: zero_out});
			if (start && !busy)
				board.note_op('{mode: mode, x: operand_x, y: operand_y, c: carry_in,
					n: negative_in, v: overflow_in, h: half_carry_in, z: zero_in});
		end
	end

	function automatic logic [DataW-1:0] pick_operand();
		case ($urandom_range(0, 9))
			0: return 16'h0000;
			1: return 16'hffff;
			2: return 16'h8000;
			3: return 16'h7fff;
			4: return {8'($urandom), 8'h80};
			5: return {8'($urandom), 8'h7f};
			6: return {8'($urandom), 8'hff};
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic op_word_t random_word();
		op_word_t w;
		if ($urandom_range(0, 15) == 0)
			w.mode = ModeW'($urandom_range(MODE_SBW + 1, (1 << ModeW) - 1));
		else
			w.mode = ModeW'($urandom_range(MODE_ADC, MODE_SBW));
		w.x = pick_operand();
		w.y = pick_operand();
		{w.c, w.n, w.v, w.h, w.z} = 5'($urandom);
		return w;
	endfunction

	task automatic drive_fields(op_word_t w);
		mode = w.mode;
		operand_x = w.x;
		operand_y = w.y;
		carry_in = w.c;
		negative_in = w.n;
		overflow_in = w.v;
		half_carry_in = w.h;
		zero_in = w.z;
	endtask

	task automatic send_word(op_word_t w);
		@(negedge clk);
		start = 1'b1;
		drive_fields(w);
		do @(posedge clk); while (busy);
	endtask

	task automatic send_op(logic [ModeW-1:0] m, logic [DataW-1:0] x, logic [DataW-1:0] y,
		logic [4:0] cnvhz);
		send_word('{mode: m, x: x, y: y, c: cnvhz[4], n: cnvhz[3], v: cnvhz[2],
			h: cnvhz[1], z: cnvhz[0]});
	endtask

	task automatic idle_cycle();
		@(negedge clk);
		start = 1'b0;
		drive_fields(random_word());
	endtask

	// hold start low until every outstanding word has come back
	task automatic drain();
		@(negedge clk);
		start = 1'b0;
		while (board.expected_words.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		int idle_pct[Phases];
		int gap;
		board = new();
		idle_pct = '{0, 62, 0, 28};
		clk = 1'b0;
		cycle_count = 0;
		arst_n = 1'b0;
		start = 1'b0;
		drive_fields('0);
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// corners of every operation, flags as {c, n, v, h, z}
		send_op(MODE_ADC, 16'hff7f, 16'h0001, 5'b00000);
		send_op(MODE_ADC, 16'h00ff, 16'hff00, 5'b10000);
		send_op(MODE_AND, 16'hffff, 16'h0000, 5'b01111);
		send_op(MODE_ASL, 16'hff80, 16'hffff, 5'b00000);
		send_op(MODE_CMP, 16'h0010, 16'h0010, 5'b01000);
		send_op(MODE_CMP, 16'h0000, 16'h00ff, 5'b10001);
		send_op(MODE_DEC, 16'h0000, 16'h0000, 5'b00001);
		send_op(MODE_INC, 16'hffff, 16'h0000, 5'b00000);
		send_op(MODE_EOR, 16'hffff, 16'hffff, 5'b11110);
		send_op(MODE_LD, 16'h0000, 16'hff80, 5'b00001);
		send_op(MODE_LSR, 16'h0001, 16'h0000, 5'b01000);
		send_op(MODE_OR, 16'h0000, 16'hff00, 5'b01000);
		send_op(MODE_ROL, 16'h0080, 16'h0000, 5'b10000);
		send_op(MODE_ROR, 16'h0001, 16'h0000, 5'b10000);
		send_op(MODE_SBC, 16'h0000, 16'h0001, 5'b10000);
		send_op(MODE_SBC, 16'h0080, 16'h0001, 5'b10000);
		send_op(MODE_ST, 16'h1234, 16'habcd, 5'b11111);
		send_op(MODE_ADW, 16'hffff, 16'h0001, 5'b10000);
		send_op(MODE_ADW, 16'h7fff, 16'h0001, 5'b00000);
		send_op(MODE_CPW, 16'h0000, 16'hffff, 5'b10000);
		send_op(MODE_CPW, 16'hffff, 16'hffff, 5'b00000);
		send_op(MODE_LDW, 16'h0000, 16'h8000, 5'b00000);
		send_op(MODE_LDW, 16'hffff, 16'h0000, 5'b10110);
		send_op(MODE_SBW, 16'h0000, 16'h0001, 5'b00000);
		send_op(ModeW'(MODE_SBW + 1), 16'hffff, 16'hffff, 5'b11111);
		send_op({ModeW{1'b1}}, 16'hffff, 16'hffff, 5'b01010);
		drain();

		for (int p = 0; p < Phases; p++) begin
			for (int i = 0; i < RandomWords / Phases; i++) begin
				if ($urandom_range(0, 99) < idle_pct[p]) begin
					gap = $urandom_range(1, 4);
					repeat (gap) idle_cycle();
				end
				send_word(random_word());
			end
			drain();
		end

		repeat (6) @(posedge clk);
		@(negedge clk);
		if (board.mismatches == 0 && board.expected_words.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/alusf_pkg.sv
hw/rtl/alusf_exec.sv
hw/rtl/alu_8_16_bit_with_status_flags_core.sv
bench/alu_8_16_bit_with_status_flags_core_test.sv
